// ===== design/pnrl_pkg.sv =====
// ----------------------------------------------------------------------------
// pnrl_pkg: shared types and constants for the polyline nearest-point unit
// Sequencer states, operation codes and register indexes.
// ----------------------------------------------------------------------------
package pnrl_pkg;

   localparam int COORD_W = 16;
   localparam int DIST_W  = 17;
   localparam int LEN_W   = 24;
   localparam int IDX_W   = 6;

   localparam logic [1:0] CSR_QUERY_X     = 2'd0;
   localparam logic [1:0] CSR_QUERY_Y     = 2'd1;
   localparam logic [1:0] CSR_START_INDEX = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIVLD,
      ST_DIV,
      ST_SQRT,
      ST_WB,
      ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_VX, OP_VY, OP_VSQ,
      OP_DX, OP_DY, OP_LSQ,
      OP_NX, OP_NY,
      OP_MX, OP_MY,
      OP_QX, OP_QY, OP_QSQ,
      OP_RX, OP_RY, OP_RSQ
   } op_type;

endpackage

// ===== design/polyline_nearest_and_remaining_length_unit.sv =====
// ----------------------------------------------------------------------------
// polyline_nearest_and_remaining_length_unit
// Streams path vertices and reports the nearest segment, point and vertex to
// a query point together with total and remaining path lengths.
// ----------------------------------------------------------------------------
// Usage:
//   Program query_x, query_y and start_index on the csr port while idle.
//   Send vertices on req_*; req_last marks the final vertex of a path.
//   One item appears on rsp_* per path, after its last vertex is processed.
// Operation:
//   All arithmetic runs on one shared shift-add multiplier, one restoring
//   divider and one square-root recurrence, each operation framed by a
//   setup and a writeback step; a division also takes a load step. The
//   first vertex of a path only needs its distance to the query point;
//   later vertices add segment length and projection work, more when the
//   projection falls inside the segment and more again when the segment
//   becomes the nearest one. Vertices past MAX_POINTS are accepted but
//   only set the overflow flag. req_stall is high while busy.
// Output:
//   rsp_* is a register; a result waiting under rsp_stall does not block
//   the next path, only the emission of the following result.
// Reset:
//   Synchronous; clears state, CSRs, count, overflow, total, pending result.
// ----------------------------------------------------------------------------
module polyline_nearest_and_remaining_length_unit #(
   parameter int MAX_POINTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [pnrl_pkg::COORD_W-1:0] req_vertex_x,
   input  logic signed [pnrl_pkg::COORD_W-1:0] req_vertex_y,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pnrl_pkg::LEN_W-1:0]          rsp_remaining_length,
   output logic [pnrl_pkg::LEN_W-1:0]          rsp_total_length,
   output logic [pnrl_pkg::DIST_W-1:0]         rsp_min_distance,
   output logic [pnrl_pkg::IDX_W-1:0]          rsp_segment_index,
   output logic signed [pnrl_pkg::COORD_W-1:0] rsp_nearest_x,
   output logic signed [pnrl_pkg::COORD_W-1:0] rsp_nearest_y,
   output logic [pnrl_pkg::IDX_W-1:0]          rsp_vertex_index,
   output logic                                rsp_has_segment,
   output logic                                rsp_overflow,
   input  logic                                csr_write_enable,
   input  logic [1:0]                          csr_index,
   input  logic [pnrl_pkg::COORD_W-1:0]        csr_data
);
   import pnrl_pkg::*;

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int SW = (CW > IDX_W) ? CW : IDX_W;
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   function automatic logic [15:0] absdiff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
      logic signed [16:0] d;
      logic signed [16:0] m;
      d = {a[15], a} - {b[15], b};
      m = d[16] ? -d : d;
      return m[15:0];
   endfunction

   function automatic logic negdiff(input logic signed [15:0] a,
                                    input logic signed [15:0] b);
      logic signed [16:0] d;
      d = {a[15], a} - {b[15], b};
      return d[16];
   endfunction

   function automatic logic [LEN_W-1:0] satadd(input logic [LEN_W-1:0] a,
                                               input logic [DIST_W-1:0] b);
      logic [LEN_W:0] s;
      s = {1'b0, a} + {{(LEN_W + 1 - DIST_W){1'b0}}, b};
      return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
   endfunction

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [IDX_W-1:0]   start_ff, start_in;

   logic signed [15:0] vx_ff, vx_in, vy_ff, vy_in;
   logic               last_ff, last_in;

   logic signed [15:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               over_ff, over_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]   best_seg_ff, best_seg_in;
   logic signed [15:0] bpx_ff, bpx_in, bpy_ff, bpy_in;
   logic [LEN_W-1:0]   rem_ff, rem_in, tot_ff, tot_in;
   logic [IDX_W-1:0]   bvert_ff, bvert_in;
   logic [DIST_W-1:0]  bvdist_ff, bvdist_in;

   logic [33:0]        l2_ff, l2_in;
   logic [32:0]        n_ff, n_in;
   logic [DIST_W-1:0]  seglen_ff, seglen_in;
   logic signed [15:0] px_ff, px_in, py_ff, py_in;

   logic signed [51:0] acc_ff, acc_in;
   logic [49:0]        ma_ff, ma_in;
   logic [15:0]        mb_ff, mb_in;
   logic               mneg_ff, mneg_in;
   logic [4:0]         ucnt_ff, ucnt_in;

   logic [33:0]        dr_ff, dr_in;
   logic [16:0]        dn_ff, dn_in;
   logic [16:0]        q_ff, q_in;

   logic [33:0]        sx_ff, sx_in, sr_ff, sr_in, sbit_ff, sbit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]    rsp_rem_ff, rsp_rem_in, rsp_tot_ff, rsp_tot_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [IDX_W-1:0]    rsp_seg_ff, rsp_seg_in, rsp_vert_ff, rsp_vert_in;
   logic signed [15:0]  rsp_nx_ff, rsp_nx_in, rsp_ny_ff, rsp_ny_in;
   logic                rsp_has_ff, rsp_has_in, rsp_over_ff, rsp_over_in;

   logic [CW-1:0]       seg;
   logic [DIST_W-1:0]   sres;
   logic [34:0]         ssum;
   logic [34:0]         dt;
   logic [34:0]         dv;
   logic                dge;
   logic                accept;
   logic                fin;
   logic                has_seg;
   logic signed [17:0]  pq;

   assign seg    = cnt_ff - CW'(1);
   assign sres   = sr_ff[16:0] + 17'(sx_ff > sr_ff);
   assign ssum   = {1'b0, sr_ff} + {1'b0, sbit_ff};
   assign dt     = {dr_ff, dn_ff[16]};
   assign dv     = {l2_ff, 1'b0};
   assign dge    = dt >= dv;
   assign accept = req_valid && !req_stall;
   assign has_seg = cnt_ff >= CW'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      start_in     = start_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      last_in      = last_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      cnt_in       = cnt_ff;
      over_in      = over_ff;
      best_dist_in = best_dist_ff;
      best_seg_in  = best_seg_ff;
      bpx_in       = bpx_ff;
      bpy_in       = bpy_ff;
      rem_in       = rem_ff;
      tot_in       = tot_ff;
      bvert_in     = bvert_ff;
      bvdist_in    = bvdist_ff;
      l2_in        = l2_ff;
      n_in         = n_ff;
      seglen_in    = seglen_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      acc_in       = acc_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      mneg_in      = mneg_ff;
      ucnt_in      = ucnt_ff;
      dr_in        = dr_ff;
      dn_in        = dn_ff;
      q_in         = q_ff;
      sx_in        = sx_ff;
      sr_in        = sr_ff;
      sbit_in      = sbit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rem_in   = rsp_rem_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_vert_in  = rsp_vert_ff;
      rsp_nx_in    = rsp_nx_ff;
      rsp_ny_in    = rsp_ny_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_over_in  = rsp_over_ff;
      fin          = 1'b0;
      pq           = '0;
      req_stall    = state_ff != ST_IDLE;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_QUERY_X:     qx_in = csr_data;
            CSR_QUERY_Y:     qy_in = csr_data;
            CSR_START_INDEX: start_in = csr_data[IDX_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               vx_in   = req_vertex_x;
               vy_in   = req_vertex_y;
               last_in = req_last;
               if (cnt_ff == CW'(MAX_POINTS)) begin
                  over_in  = 1'b1;
                  state_in = req_last ? ST_OUT : ST_IDLE;
               end else begin
                  op_in    = OP_VX;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            acc_in   = '0;
            mneg_in  = 1'b0;
            ucnt_in  = '0;
            sr_in    = '0;
            sbit_in  = 34'(1) << 32;
            sx_in    = acc_ff[33:0];
            state_in = ST_MUL;
            case (op_ff)
               OP_VX: begin
                  ma_in = 50'(absdiff(vx_ff, qx_ff));
                  mb_in = absdiff(vx_ff, qx_ff);
               end
               OP_VY: begin
                  acc_in = acc_ff;
                  ma_in  = 50'(absdiff(vy_ff, qy_ff));
                  mb_in  = absdiff(vy_ff, qy_ff);
               end
               OP_DX: begin
                  ma_in = 50'(absdiff(vx_ff, prev_x_ff));
                  mb_in = absdiff(vx_ff, prev_x_ff);
               end
               OP_DY: begin
                  acc_in = acc_ff;
                  ma_in  = 50'(absdiff(vy_ff, prev_y_ff));
                  mb_in  = absdiff(vy_ff, prev_y_ff);
               end
               OP_NX: begin
                  ma_in   = 50'(absdiff(qx_ff, prev_x_ff));
                  mb_in   = absdiff(vx_ff, prev_x_ff);
                  mneg_in = negdiff(qx_ff, prev_x_ff) ^ negdiff(vx_ff, prev_x_ff);
               end
               OP_NY: begin
                  acc_in  = acc_ff;
                  ma_in   = 50'(absdiff(qy_ff, prev_y_ff));
                  mb_in   = absdiff(vy_ff, prev_y_ff);
                  mneg_in = negdiff(qy_ff, prev_y_ff) ^ negdiff(vy_ff, prev_y_ff);
               end
               OP_MX: begin
                  acc_in = 52'(l2_ff);
                  ma_in  = 50'({n_ff, 1'b0});
                  mb_in  = absdiff(vx_ff, prev_x_ff);
               end
               OP_MY: begin
                  acc_in = 52'(l2_ff);
                  ma_in  = 50'({n_ff, 1'b0});
                  mb_in  = absdiff(vy_ff, prev_y_ff);
               end
               OP_QX: begin
                  ma_in = 50'(absdiff(px_ff, qx_ff));
                  mb_in = absdiff(px_ff, qx_ff);
               end
               OP_QY: begin
                  acc_in = acc_ff;
                  ma_in  = 50'(absdiff(py_ff, qy_ff));
                  mb_in  = absdiff(py_ff, qy_ff);
               end
               OP_RX: begin
                  ma_in = 50'(absdiff(px_ff, vx_ff));
                  mb_in = absdiff(px_ff, vx_ff);
               end
               OP_RY: begin
                  acc_in = acc_ff;
                  ma_in  = 50'(absdiff(py_ff, vy_ff));
                  mb_in  = absdiff(py_ff, vy_ff);
               end
               OP_LSQ: begin
                  sx_in    = l2_ff;
                  state_in = ST_SQRT;
               end
               default: begin
                  // root of the accumulated square sum
                  state_in = ST_SQRT;
               end
            endcase
         end
         ST_MUL: begin
            if (mb_ff[0]) begin
               acc_in = mneg_ff ? acc_ff - $signed({2'b00, ma_ff})
                                : acc_ff + $signed({2'b00, ma_ff});
            end
            ma_in   = ma_ff << 1;
            mb_in   = mb_ff >> 1;
            ucnt_in = ucnt_ff + 5'd1;
            if (ucnt_ff == 5'd15) begin
               state_in = (op_ff == OP_MX || op_ff == OP_MY) ? ST_DIVLD : ST_WB;
            end
         end
         ST_DIVLD: begin
            dr_in    = acc_ff[50:17];
            dn_in    = acc_ff[16:0];
            q_in     = '0;
            ucnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dr_in   = dge ? 34'(dt - dv) : dt[33:0];
            q_in    = {q_ff[15:0], dge};
            dn_in   = dn_ff << 1;
            ucnt_in = ucnt_ff + 5'd1;
            if (ucnt_ff == 5'd16) begin
               state_in = ST_WB;
            end
         end
         ST_SQRT: begin
            if ({1'b0, sx_ff} >= ssum) begin
               sx_in = 34'({1'b0, sx_ff} - ssum);
               sr_in = (sr_ff >> 1) + sbit_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (sbit_ff[0]) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            state_in = ST_SETUP;
            case (op_ff)
               OP_VX: op_in = OP_VY;
               OP_VY: op_in = OP_VSQ;
               OP_VSQ: begin
                  if (cnt_ff == '0 || sres < bvdist_ff) begin
                     bvert_in  = IDX_W'(cnt_ff);
                     bvdist_in = sres;
                  end
                  if (cnt_ff == '0) begin
                     fin = 1'b1;
                  end else begin
                     op_in = OP_DX;
                  end
               end
               OP_DX: op_in = OP_DY;
               OP_DY: begin
                  l2_in = acc_ff[33:0];
                  op_in = OP_LSQ;
               end
               OP_LSQ: begin
                  seglen_in = sres;
                  if (SW'(seg) >= SW'(start_ff)) begin
                     tot_in = satadd(tot_ff, sres);
                  end
                  op_in = OP_NX;
               end
               OP_NX: op_in = OP_NY;
               OP_NY: begin
                  n_in = acc_ff[32:0];
                  if (l2_ff == '0 || acc_ff[51] || acc_ff == '0) begin
                     px_in = prev_x_ff;
                     py_in = prev_y_ff;
                     op_in = OP_QX;
                  end else if (acc_ff >= $signed(52'(l2_ff))) begin
                     px_in = vx_ff;
                     py_in = vy_ff;
                     op_in = OP_QX;
                  end else begin
                     op_in = OP_MX;
                  end
               end
               OP_MX: begin
                  pq = negdiff(vx_ff, prev_x_ff)
                     ? {{2{prev_x_ff[15]}}, prev_x_ff} - $signed({1'b0, q_ff})
                     : {{2{prev_x_ff[15]}}, prev_x_ff} + $signed({1'b0, q_ff});
                  px_in = pq[15:0];
                  op_in = OP_MY;
               end
               OP_MY: begin
                  pq = negdiff(vy_ff, prev_y_ff)
                     ? {{2{prev_y_ff[15]}}, prev_y_ff} - $signed({1'b0, q_ff})
                     : {{2{prev_y_ff[15]}}, prev_y_ff} + $signed({1'b0, q_ff});
                  py_in = pq[15:0];
                  op_in = OP_QX;
               end
               OP_QX: op_in = OP_QY;
               OP_QY: op_in = OP_QSQ;
               OP_QSQ: begin
                  if (seg == '0 || sres < best_dist_ff) begin
                     best_dist_in = sres;
                     best_seg_in  = IDX_W'(seg);
                     bpx_in       = px_ff;
                     bpy_in       = py_ff;
                     op_in        = OP_RX;
                  end else begin
                     rem_in = satadd(rem_ff, seglen_ff);
                     fin    = 1'b1;
                  end
               end
               OP_RX: op_in = OP_RY;
               OP_RY: op_in = OP_RSQ;
               default: begin
                  rem_in = LEN_W'(sres);
                  fin    = 1'b1;
               end
            endcase
            if (fin) begin
               prev_x_in = vx_ff;
               prev_y_in = vy_ff;
               cnt_in    = cnt_ff + CW'(1);
               state_in  = last_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_rem_in   = has_seg ? rem_ff : '0;
               rsp_tot_in   = tot_ff;
               rsp_dist_in  = has_seg ? best_dist_ff : '0;
               rsp_seg_in   = has_seg ? best_seg_ff : '0;
               rsp_nx_in    = has_seg ? bpx_ff : '0;
               rsp_ny_in    = has_seg ? bpy_ff : '0;
               rsp_vert_in  = bvert_ff;
               rsp_has_in   = has_seg;
               rsp_over_in  = over_ff;
               cnt_in       = '0;
               over_in      = 1'b0;
               tot_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_VX;
         qx_ff        <= '0;
         qy_ff        <= '0;
         start_ff     <= '0;
         cnt_ff       <= '0;
         over_ff      <= 1'b0;
         tot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_ff        <= op_in;
         qx_ff        <= qx_in;
         qy_ff        <= qy_in;
         start_ff     <= start_in;
         cnt_ff       <= cnt_in;
         over_ff      <= over_in;
         tot_ff       <= tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      last_ff      <= last_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      best_dist_ff <= best_dist_in;
      best_seg_ff  <= best_seg_in;
      bpx_ff       <= bpx_in;
      bpy_ff       <= bpy_in;
      rem_ff       <= rem_in;
      bvert_ff     <= bvert_in;
      bvdist_ff    <= bvdist_in;
      l2_ff        <= l2_in;
      n_ff         <= n_in;
      seglen_ff    <= seglen_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      acc_ff       <= acc_in;
      ma_ff        <= ma_in;
      mb_ff        <= mb_in;
      mneg_ff      <= mneg_in;
      ucnt_ff      <= ucnt_in;
      dr_ff        <= dr_in;
      dn_ff        <= dn_in;
      q_ff         <= q_in;
      sx_ff        <= sx_in;
      sr_ff        <= sr_in;
      sbit_ff      <= sbit_in;
      rsp_rem_ff   <= rsp_rem_in;
      rsp_tot_ff   <= rsp_tot_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_vert_ff  <= rsp_vert_in;
      rsp_nx_ff    <= rsp_nx_in;
      rsp_ny_ff    <= rsp_ny_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_over_ff  <= rsp_over_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_remaining_length = rsp_rem_ff;
   assign rsp_total_length     = rsp_tot_ff;
   assign rsp_min_distance     = rsp_dist_ff;
   assign rsp_segment_index    = rsp_seg_ff;
   assign rsp_nearest_x        = rsp_nx_ff;
   assign rsp_nearest_y        = rsp_ny_ff;
   assign rsp_vertex_index     = rsp_vert_ff;
   assign rsp_has_segment      = rsp_has_ff;
   assign rsp_overflow         = rsp_over_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_POINTS))
      else $error("vertex count beyond limit");

   a_root_bit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQRT |-> $onehot(sbit_ff))
      else $error("square root bit lost");

   a_no_segment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_segment |->
         rsp_min_distance == '0 && rsp_remaining_length == '0)
      else $error("segment fields set without a segment");

endmodule
